@@ sv/rrp_pkg.sv @@
// ----------------------------------------------------------------------------
// rrp_pkg: shared types and constants for the ROM read patcher
// Bus access kinds, mode codes, register map offsets and the write request
// that the access decoder hands to the code bank.
// ----------------------------------------------------------------------------
package rrp_pkg;

  // Bus access kinds carried in the input tuser bit.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Operating modes reported with every result item.
  localparam logic [1:0] MODE_PASS  = 2'd0;
  localparam logic [1:0] MODE_BOOT  = 2'd1;
  localparam logic [1:0] MODE_PATCH = 2'd2;

  // Register map. The control register sits at the base; each code then
  // occupies four consecutive bytes starting one above the base.
  localparam logic [15:0] CTRL_BASE    = 16'h8000;
  localparam logic [1:0]  FLD_ADDR_HI  = 2'd0;
  localparam logic [1:0]  FLD_ADDR_LO  = 2'd1;
  localparam logic [1:0]  FLD_COMPARE  = 2'd2;
  localparam logic [1:0]  FLD_REPLACE  = 2'd3;
  localparam int          CODE_STRIDE  = 4;

  // Control byte that loads all-zero control bits instead of its inverse.
  localparam logic [7:0] CTRL_CLEAR_KEY = 8'h71;
  // Bit forced on in every loaded address high byte.
  localparam logic [7:0] ADDR_HI_FORCE  = 8'h80;

  // Reset contents of the code registers.
  localparam logic [7:0]  BYTE_RESET = 8'hFF;
  localparam logic [15:0] ADDR_RESET = 16'hFFFF;

  // Width of the boot ROM offset.
  localparam int BOOT_OFS_W = 12;

  // Register write request from the access decoder to the code bank.
  typedef struct packed {
    logic        valid;
    logic [15:0] addr;
    logic [7:0]  data;
  } rrp_bus_wr_t;

endpackage

@@ sv/rrp_code_bank.sv @@
// ----------------------------------------------------------------------------
// rrp_code_bank: patch code registers, control bits, mode and patch chain
// Holds the loaded codes, applies register writes in boot mode and replaces
// read data with the enabled matching codes in order.
// ----------------------------------------------------------------------------
module rrp_code_bank
  import rrp_pkg::*;
#(
  parameter int CODE_COUNT = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  rrp_bus_wr_t wr,
  input  logic [15:0] rd_addr,
  input  logic [7:0]  rd_data,
  output logic [1:0]  mode,
  output logic [7:0]  patched_data
);

  localparam int CTRL_W = 2 * CODE_COUNT;

  logic [15:0]       patch_address [CODE_COUNT];
  logic [7:0]        compare_byte  [CODE_COUNT];
  logic [7:0]        replace_byte  [CODE_COUNT];
  logic [CTRL_W-1:0] control_bits;
  logic [CTRL_W-1:0] control_bits_next;
  logic [7:0]        ctrl_byte;
  logic [7:0]        ctrl_shift;

  // The stored control value is the inverted byte shifted down by one.
  assign ctrl_byte  = (wr.data == CTRL_CLEAR_KEY) ? 8'h00 : ~wr.data;
  assign ctrl_shift = {1'b0, ctrl_byte[7:1]};

  for (genvar gi = 0; gi < CTRL_W; gi++) begin : g_ctrl
    if (gi < 8) begin : g_in
      assign control_bits_next[gi] = ctrl_shift[gi];
    end else begin : g_out
      assign control_bits_next[gi] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_BOOT;
      control_bits <= '0;
      for (int k = 0; k < CODE_COUNT; k++) begin
        patch_address[k] <= ADDR_RESET;
        compare_byte[k]  <= BYTE_RESET;
        replace_byte[k]  <= BYTE_RESET;
      end
    end else if (wr.valid && mode == MODE_BOOT) begin
      if (wr.addr == CTRL_BASE) begin
        if (wr.data == 8'h00) begin
          mode <= MODE_PATCH;
        end else begin
          control_bits <= control_bits_next;
        end
      end
      for (int k = 0; k < CODE_COUNT; k++) begin
        if (wr.addr == CTRL_BASE + 16'(1 + CODE_STRIDE * k) + 16'(FLD_ADDR_HI)) begin
          patch_address[k][15:8] <= wr.data | ADDR_HI_FORCE;
        end
        if (wr.addr == CTRL_BASE + 16'(1 + CODE_STRIDE * k) + 16'(FLD_ADDR_LO)) begin
          patch_address[k][7:0] <= wr.data;
        end
        if (wr.addr == CTRL_BASE + 16'(1 + CODE_STRIDE * k) + 16'(FLD_COMPARE)) begin
          compare_byte[k] <= wr.data;
        end
        if (wr.addr == CTRL_BASE + 16'(1 + CODE_STRIDE * k) + 16'(FLD_REPLACE)) begin
          replace_byte[k] <= wr.data;
        end
      end
    end
  end

  // Each code acts on the result of the one before it.
  always_comb begin
    patched_data = rd_data;
    for (int k = 0; k < CODE_COUNT; k++) begin
      if (control_bits[CODE_COUNT + k] && patch_address[k] == rd_addr) begin
        if (control_bits[k] || patched_data == compare_byte[k]) begin
          patched_data = replace_byte[k];
        end
      end
    end
  end

endmodule

@@ sv/rom_read_patch_cheat_device.sv @@
// ----------------------------------------------------------------------------
// rom_read_patch_cheat_device: compare-and-replace read patcher top level
// Input register, access decode and patch chain, result register.
// ----------------------------------------------------------------------------
// This block sits inline on an 8-bit CPU bus and takes one bus access per
// input item, returning exactly one result item for each. After reset it is in
// boot mode: writes at 0x8001 and up load the patch codes (four bytes per code:
// address high with bit 7 forced on, address low, compare byte, replace byte),
// a nonzero write at 0x8000 loads the control bits, and a zero write at 0x8000
// switches to patching mode until the next reset. In boot mode, reads at 0x8000
// and above are flagged for the external boot ROM with the low twelve address
// bits as the offset. In patching mode every enabled code whose address matches
// a read replaces the cartridge byte, either always or only when the byte equals
// the code's compare byte; codes apply in order. Clearing cfg_wdata makes every
// access pass through untouched while the loaded state is kept. An item passes
// through the input register and then the result register, and a new item is
// taken every cycle while the result side keeps taking items; throughput is set
// only by how promptly the result side takes items.
module rom_read_patch_cheat_device
  import rrp_pkg::*;
#(
  parameter int CODE_COUNT = 3
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: device present bit.
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  // Bus access items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] address, [23:16] write_data, [31:24] cart_data
  input  logic [31:0] s_axis_tdata,
  // [0] opcode
  input  logic        s_axis_tuser,
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] read_data, [19:8] boot_rom_offset, [21:20] current_mode, [23:22] zero
  output logic [23:0] m_axis_tdata,
  // [0] boot_rom_select, [1] forward_write
  output logic [1:0]  m_axis_tuser
);

  // Configuration register; the device counts as present after reset.
  logic device_present;

  // Input register.
  logic        in_valid;
  logic        in_opcode;
  logic [15:0] in_address;
  logic [7:0]  in_write_data;
  logic [7:0]  in_cart_data;

  // Result register.
  logic                  out_valid;
  logic [7:0]            out_read_data;
  logic                  out_boot_rom_select;
  logic [BOOT_OFS_W-1:0] out_boot_rom_offset;
  logic                  out_forward_write;
  logic [1:0]            out_current_mode;

  // Decode of the item in the input register.
  logic                  advance;
  logic                  fire;
  logic                  is_write;
  logic                  high_range;
  logic [1:0]            mode;
  logic [7:0]            patched_data;
  rrp_bus_wr_t           bank_wr;
  logic [7:0]            read_data_next;
  logic                  boot_rom_select_next;
  logic [BOOT_OFS_W-1:0] boot_rom_offset_next;
  logic                  forward_write_next;
  logic [1:0]            current_mode_next;

  // The result register frees up when empty or when its item is taken; the
  // input register can then move on, and it refills in the same cycle.
  assign advance       = !out_valid || m_axis_tready;
  assign fire          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_present <= 1'b1;
    end else if (cfg_we) begin
      device_present <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_opcode     <= s_axis_tuser;
      in_address    <= s_axis_tdata[15:0];
      in_write_data <= s_axis_tdata[23:16];
      in_cart_data  <= s_axis_tdata[31:24];
    end
  end

  assign is_write   = (in_opcode == OP_WRITE);
  assign high_range = (in_address >= CTRL_BASE);

  // Only boot-mode writes in the register range reach the code bank, and only
  // once, in the cycle the item moves into the result register.
  assign bank_wr.valid = fire && device_present && (mode == MODE_BOOT) && is_write
                         && high_range;
  assign bank_wr.addr  = in_address;
  assign bank_wr.data  = in_write_data;

  rrp_code_bank #(
    .CODE_COUNT(CODE_COUNT)
  ) u_code_bank (
    .clk         (clk),
    .rst         (rst),
    .wr          (bank_wr),
    .rd_addr     (in_address),
    .rd_data     (in_cart_data),
    .mode        (mode),
    .patched_data(patched_data)
  );

  always_comb begin
    read_data_next       = 8'h00;
    boot_rom_select_next = 1'b0;
    boot_rom_offset_next = '0;
    forward_write_next   = 1'b0;
    current_mode_next    = mode;
    if (!device_present) begin
      // Device absent: plain pass-through.
      current_mode_next = MODE_PASS;
      if (is_write) begin
        forward_write_next = 1'b1;
      end else begin
        read_data_next = in_cart_data;
      end
    end else if (mode == MODE_BOOT) begin
      if (is_write) begin
        forward_write_next = !high_range;
        // The reported mode already reflects a switch made by this write.
        if (high_range && in_address == CTRL_BASE && in_write_data == 8'h00) begin
          current_mode_next = MODE_PATCH;
        end
      end else if (high_range) begin
        boot_rom_select_next = 1'b1;
        boot_rom_offset_next = in_address[BOOT_OFS_W-1:0];
      end else begin
        read_data_next = in_cart_data;
      end
    end else begin
      if (is_write) begin
        forward_write_next = 1'b1;
      end else begin
        read_data_next = patched_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_read_data       <= read_data_next;
      out_boot_rom_select <= boot_rom_select_next;
      out_boot_rom_offset <= boot_rom_offset_next;
      out_forward_write   <= forward_write_next;
      out_current_mode    <= current_mode_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_current_mode, out_boot_rom_offset, out_read_data};
  assign m_axis_tuser  = {out_forward_write, out_boot_rom_select};

endmodule

@@ verif/rom_read_patch_cheat_device_tb.sv @@
// ----------------------------------------------------------------------------
// rom_read_patch_cheat_device_tb: self-checking bench for the ROM read patcher
// Streams bus accesses through the patcher under random back-pressure. Each
// accepted access is run through an in-bench model of the boot loader, the
// code bank and the patch chain. Every returned item is compared, field by
// field, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rom_read_patch_cheat_device_tb;
  import rrp_pkg::*;

  localparam int NCODES = 3;
  // Cycles without any handshake before the run is declared hung.
  localparam int STALL_LIMIT = 4000;

  // One bus access as the sender sees it. drain_first holds the access back
  // until every outstanding reply has come back.
  typedef struct packed {
    logic        is_write;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  cdata;
    logic        drain_first;
  } bus_access_t;

  // One reply from the patcher, unpacked from tdata and tuser.
  typedef struct packed {
    logic [7:0]  read_data;
    logic        boot_sel;
    logic [11:0] boot_ofs;
    logic        fwd;
    logic [1:0]  mode;
  } bus_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = OP_READ;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  rom_read_patch_cheat_device #(
    .CODE_COUNT(NCODES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Accesses waiting to be driven, and replies predicted for accepted ones.
  bus_access_t access_q[$];
  bus_reply_t  expected_replies[$];
  bus_access_t cur_access;

  // Shadow of the patcher state. Initial values match the reset state, and
  // reset is applied only once, at the start of the run.
  logic [7:0]        replace_shadow[NCODES] = '{default: BYTE_RESET};
  logic [7:0]        compare_shadow[NCODES] = '{default: BYTE_RESET};
  logic [15:0]       code_addr_shadow[NCODES] = '{default: ADDR_RESET};
  logic [2*NCODES-1:0] ctrl_shadow = '0;
  logic [1:0]        mode_shadow = MODE_BOOT;
  logic              present_shadow = 1'b1;

  // Codes loaded just before the switch to patching mode. Patching-mode
  // stimulus aims most reads at these addresses and compare bytes.
  logic [15:0] plan_addr[NCODES];
  logic [7:0]  plan_cmp[NCODES];
  logic [7:0]  plan_rep[NCODES];

  // Idle percentages for the sender and the receiver.
  int send_idle_pct = 23;
  int recv_stall_pct = 53;

  int n_errors = 0;
  int n_results = 0;
  int n_reads = 0;
  int n_writes = 0;
  int n_boot_rom = 0;
  int n_replaced = 0;
  int n_cfg_writes = 0;
  int idle_cycles = 0;

  // 12 ns clock.
  initial begin
    forever #6 clk = ~clk;
  end

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    n_errors++;
    $display("[%0t] reply %0d: %s got 0x%0h expected 0x%0h",
             $realtime, n_results, what, got, want);
  endtask

  // Works out the reply to one accepted access and advances the shadow state.
  function automatic bus_reply_t predict_reply(bus_access_t a);
    bus_reply_t  r;
    logic [7:0]  d;
    logic [7:0]  c;
    logic [15:0] ofs;
    int          k;
    r = '0;
    if (a.is_write) n_writes++;
    else n_reads++;
    // With the device pulled out everything passes straight through and the
    // loaded codes are left alone.
    if (!present_shadow) begin
      r.mode = MODE_PASS;
      if (a.is_write) r.fwd = 1'b1;
      else r.read_data = a.cdata;
      return r;
    end
    if (mode_shadow == MODE_BOOT) begin
      if (a.is_write && a.addr >= CTRL_BASE) begin
        if (a.addr == CTRL_BASE) begin
          // A zero byte leaves boot mode for good; any other byte loads the
          // inverted control bits, except the clear key, which loads zero.
          if (a.wdata == 8'h00) begin
            mode_shadow = MODE_PATCH;
          end else begin
            c = (a.wdata == CTRL_CLEAR_KEY) ? 8'h00 : ~a.wdata;
            ctrl_shadow = c[2*NCODES:1];
          end
        end else if (a.addr <= CTRL_BASE + 16'(CODE_STRIDE * NCODES)) begin
          ofs = a.addr - CTRL_BASE - 16'd1;
          k = int'(ofs) / CODE_STRIDE;
          case (ofs[1:0])
            FLD_ADDR_HI: code_addr_shadow[k][15:8] = a.wdata | ADDR_HI_FORCE;
            FLD_ADDR_LO: code_addr_shadow[k][7:0] = a.wdata;
            FLD_COMPARE: compare_shadow[k] = a.wdata;
            default:     replace_shadow[k] = a.wdata;
          endcase
        end
      end else if (a.is_write) begin
        r.fwd = 1'b1;
      end else if (a.addr >= CTRL_BASE) begin
        r.boot_sel = 1'b1;
        r.boot_ofs = a.addr[BOOT_OFS_W-1:0];
        n_boot_rom++;
      end else begin
        r.read_data = a.cdata;
      end
    end else if (a.is_write) begin
      r.fwd = 1'b1;
    end else begin
      // Patch chain: each enabled code sees the byte left by the one before.
      d = a.cdata;
      for (k = 0; k < NCODES; k++) begin
        if (ctrl_shadow[NCODES+k] && code_addr_shadow[k] == a.addr &&
            (ctrl_shadow[k] || d == compare_shadow[k])) begin
          d = replace_shadow[k];
          n_replaced++;
        end
      end
      r.read_data = d;
    end
    r.mode = mode_shadow;
    return r;
  endfunction

  function automatic void add_access(logic is_write, logic [15:0] addr, logic [7:0] wdata,
                                     logic [7:0] cdata, logic drain_first = 1'b0);
    bus_access_t a;
    a.is_write = is_write;
    a.addr = addr;
    a.wdata = wdata;
    a.cdata = cdata;
    a.drain_first = drain_first;
    access_q.push_back(a);
  endfunction

  // Unconstrained access, with the patching switch byte thrown in now and then.
  function automatic void add_random_access();
    if ($urandom_range(99) < 10) begin
      add_access(OP_WRITE, CTRL_BASE, 8'h00, 8'($urandom_range(255)));
    end else begin
      add_access(1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)),
                 8'($urandom_range(255)), 8'($urandom_range(255)));
    end
  endfunction

  // Patching-mode traffic: mostly reads that hit a loaded code, with the
  // cartridge byte often equal to its compare byte.
  function automatic void add_patch_access(logic drain_first);
    int          r;
    int          k;
    logic [7:0]  cd;
    r = $urandom_range(99);
    k = $urandom_range(NCODES - 1);
    case ($urandom_range(2))
      0:       cd = plan_cmp[k];
      1:       cd = plan_cmp[k] ^ (8'h01 << $urandom_range(7));
      default: cd = 8'($urandom_range(255));
    endcase
    if (r < 55) begin
      add_access(OP_READ, plan_addr[k], 8'($urandom_range(255)), cd, drain_first);
    end else if (r < 65) begin
      // Near miss: one address bit off.
      add_access(OP_READ, plan_addr[k] ^ (16'h0001 << $urandom_range(15)),
                 8'($urandom_range(255)), cd, drain_first);
    end else if (r < 80) begin
      add_access(OP_WRITE, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), drain_first);
    end else if (r < 85) begin
      // Register writes after the switch must not touch the frozen codes.
      add_access(OP_WRITE, CTRL_BASE + 16'($urandom_range(CODE_STRIDE * NCODES)),
                 8'($urandom_range(255)), 8'($urandom_range(255)), drain_first);
    end else begin
      add_access(OP_READ, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), drain_first);
    end
  endfunction

  // Waits until nothing is queued, in flight or outstanding, then lets the
  // two pipeline stages settle.
  task automatic wait_idle();
    do @(posedge clk);
    while (access_q.size() != 0 || s_axis_tvalid || expected_replies.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_present(logic v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    present_shadow = v;
    n_cfg_writes++;
  endtask

  // Driver: presents the next queued access whenever the slot is free, idling
  // at random, and records the predicted reply for each accepted access.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_replies.push_back(predict_reply(cur_access));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (access_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            !(access_q[0].drain_first && expected_replies.size() != 0)) begin
          cur_access = access_q.pop_front();
          s_axis_tdata <= {cur_access.cdata, cur_access.wdata, cur_access.addr};
          s_axis_tuser <= cur_access.is_write ? OP_WRITE : OP_READ;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted reply against the oldest prediction and
  // stalls the result side at random.
  always @(posedge clk) begin : reply_check
    bus_reply_t got;
    bus_reply_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.read_data = m_axis_tdata[7:0];
        got.boot_ofs = m_axis_tdata[19:8];
        got.mode = m_axis_tdata[21:20];
        got.boot_sel = m_axis_tuser[0];
        got.fwd = m_axis_tuser[1];
        n_results++;
        if (expected_replies.size() == 0) begin
          report_mismatch("reply with nothing outstanding", 32'(got), 0);
        end else begin
          want = expected_replies.pop_front();
          if (got.read_data !== want.read_data)
            report_mismatch("read_data", 32'(got.read_data), 32'(want.read_data));
          if (got.boot_sel !== want.boot_sel)
            report_mismatch("boot_rom_select", 32'(got.boot_sel), 32'(want.boot_sel));
          if (got.boot_ofs !== want.boot_ofs)
            report_mismatch("boot_rom_offset", 32'(got.boot_ofs), 32'(want.boot_ofs));
          if (got.fwd !== want.fwd)
            report_mismatch("forward_write", 32'(got.fwd), 32'(want.fwd));
          if (got.mode !== want.mode)
            report_mismatch("current_mode", 32'(got.mode), 32'(want.mode));
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: any cycle with a handshake on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("rom_read_patch_cheat_device_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus sequence.
  initial begin : stimulus
    int                i;
    int                k;
    int                waited;
    logic [7:0]        hi;
    logic [NCODES-1:0] en;
    logic [NCODES-1:0] nocheck;
    logic [7:0]        ctrl_byte;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed boot-mode accesses: address and data extremes on both kinds
    // of access, code loading up to the last register and one past it, the
    // clear key and the control bytes at both ends.
    add_access(OP_READ,  16'h0000, 8'h00, 8'h00);
    add_access(OP_READ,  16'h7FFF, 8'hFF, 8'hFF);
    add_access(OP_READ,  CTRL_BASE, 8'h00, 8'h3C);  // first boot ROM byte
    add_access(OP_READ,  16'hFFFF, 8'h00, 8'hA5);   // last boot ROM byte
    add_access(OP_WRITE, 16'h0000, 8'hFF, 8'h00);
    add_access(OP_WRITE, 16'h7FFF, 8'h00, 8'hFF);
    add_access(OP_WRITE, 16'h8001, 8'h12, 8'h00);   // high byte gets bit 7 forced
    add_access(OP_WRITE, 16'h8002, 8'h34, 8'h00);
    add_access(OP_WRITE, 16'h8003, 8'h00, 8'h00);
    add_access(OP_WRITE, 16'h8004, 8'hFF, 8'h00);
    add_access(OP_WRITE, 16'h800C, 8'h5A, 8'h00);   // last code register
    add_access(OP_WRITE, 16'h800D, 8'h77, 8'h00);   // just past the code bank
    add_access(OP_WRITE, 16'hFFFF, 8'h00, 8'h00);
    add_access(OP_WRITE, CTRL_BASE, CTRL_CLEAR_KEY, 8'h00);
    add_access(OP_WRITE, CTRL_BASE, 8'h01, 8'h00);
    add_access(OP_WRITE, CTRL_BASE, 8'hFF, 8'h00);
    add_access(OP_WRITE, CTRL_BASE, 8'h80, 8'h00);

    // Device pulled out while still in boot mode: even a zero control byte
    // must pass through without leaving boot mode.
    set_present(1'b0);
    for (i = 0; i < 60; i++) add_random_access();
    set_present(1'b1);

    // Boot-mode traffic. A zero control byte is kept out so that the block
    // stays in boot mode for the whole stretch.
    for (i = 0; i < 450; i++) begin
      k = $urandom_range(99);
      if (k < 30) begin
        add_access(OP_WRITE,
                   CTRL_BASE + 16'(1 + $urandom_range(CODE_STRIDE * NCODES - 1)),
                   8'($urandom_range(255)), 8'($urandom_range(255)), i == 225);
      end else if (k < 38) begin
        add_access(OP_WRITE, CTRL_BASE, 8'($urandom_range(255, 1)),
                   8'($urandom_range(255)));
      end else if (k < 48) begin
        add_access(OP_WRITE,
                   16'($urandom_range(16'hFFFF, CTRL_BASE + CODE_STRIDE * NCODES + 1)),
                   8'($urandom_range(255)), 8'($urandom_range(255)));
      end else if (k < 60) begin
        add_access(OP_WRITE, 16'($urandom_range(CTRL_BASE - 1)), 8'($urandom_range(255)),
                   8'($urandom_range(255)));
      end else if (k < 80) begin
        add_access(OP_READ, 16'($urandom_range(16'hFFFF, CTRL_BASE)),
                   8'($urandom_range(255)), 8'($urandom_range(255)));
      end else begin
        add_access(OP_READ, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)),
                   8'($urandom_range(255)));
      end
    end

    // Final code load. Codes often share an address, and a later compare byte
    // often equals an earlier replace byte, so the chain order matters.
    for (k = 0; k < NCODES; k++) begin
      plan_addr[k] = 16'($urandom_range(16'hFFFF, CTRL_BASE));
      plan_cmp[k] = 8'($urandom_range(255));
      plan_rep[k] = 8'($urandom_range(255));
    end
    if ($urandom_range(1)) plan_addr[1] = plan_addr[0];
    if ($urandom_range(2) == 0) plan_addr[2] = plan_addr[1];
    if ($urandom_range(1)) plan_cmp[1] = plan_rep[0];
    if ($urandom_range(1)) plan_cmp[2] = plan_rep[1];
    for (k = 0; k < NCODES; k++) begin
      hi = plan_addr[k][15:8];
      if ($urandom_range(1)) hi[7] = 1'b0;
      add_access(OP_WRITE, CTRL_BASE + 16'(1 + CODE_STRIDE * k) + 16'(FLD_ADDR_HI), hi,
                 8'($urandom_range(255)));
      add_access(OP_WRITE, CTRL_BASE + 16'(1 + CODE_STRIDE * k) + 16'(FLD_ADDR_LO),
                 plan_addr[k][7:0], 8'($urandom_range(255)));
      add_access(OP_WRITE, CTRL_BASE + 16'(1 + CODE_STRIDE * k) + 16'(FLD_COMPARE),
                 plan_cmp[k], 8'($urandom_range(255)));
      add_access(OP_WRITE, CTRL_BASE + 16'(1 + CODE_STRIDE * k) + 16'(FLD_REPLACE),
                 plan_rep[k], 8'($urandom_range(255)));
    end
    // Mostly all codes enabled, with a random mix of compare and always-replace.
    en = ($urandom_range(3) == 0) ? NCODES'($urandom_range(2**NCODES - 1)) : '1;
    nocheck = NCODES'($urandom_range(2**NCODES - 1));
    ctrl_byte = ~{1'b0, en, nocheck, 1'b0};
    add_access(OP_WRITE, CTRL_BASE, ctrl_byte, 8'($urandom_range(255)));
    add_access(OP_WRITE, CTRL_BASE, 8'h00, 8'($urandom_range(255)));  // into patching mode

    // Patching mode with the idle rates swapped.
    wait_idle();
    send_idle_pct = 53;
    recv_stall_pct = 23;
    for (i = 0; i < 450; i++) add_patch_access(i == 200);

    // Pull the device out in patching mode, then plug it back in: the codes
    // must survive.
    set_present(1'b0);
    for (i = 0; i < 60; i++) add_random_access();
    set_present(1'b1);

    // Patching mode with no idling on either side.
    wait_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (i = 0; i < 500; i++) add_patch_access(1'b0);

    // Drain, with a bound on how long the last replies may take.
    do @(posedge clk);
    while (access_q.size() != 0 || s_axis_tvalid);
    waited = 0;
    while (expected_replies.size() != 0 && waited < 200) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
    while (expected_replies.size() != 0) begin
      void'(expected_replies.pop_front());
      report_mismatch("reply never returned", 0, 1);
    end

    $display("Run covered %0d accesses (%0d reads, %0d writes), %0d boot ROM reads,",
             n_reads + n_writes, n_reads, n_writes, n_boot_rom);
    $display("%0d code replacements and %0d device-present writes; %0d mismatches.",
             n_replaced, n_cfg_writes, n_errors);
    if (n_errors == 0) begin
      $display("rom_read_patch_cheat_device_tb OK");
    end else begin
      $display("rom_read_patch_cheat_device_tb NOT OK");
    end
    $finish;
  end

endmodule
